// File: design/pcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_pkg: shared types and constants for the colour gradient map
// Field widths, register layout and the colour span type passed between stages.
// ----------------------------------------------------------------------------
package pcg_pkg;

   localparam int NUM_POINTS_DEF    = 7;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 16;

   // Register file layout: breakpoint value above the RGB888 colour.
   localparam int REG_COUNT      = 7;
   localparam int CSR_INDEX_BITS = 3;
   localparam int POINT_BITS     = 40;
   localparam int VALUE_BITS     = 16;
   localparam int VALUE_LSB      = 24;
   localparam int COLOUR_BITS    = 24;
   localparam int CHANNEL_BITS   = 8;
   localparam int NUM_CHANNELS   = 3;
   localparam int PACKED_BITS    = 16;

   // Segment numerator and denominator are below 2^17; the divider remainder
   // needs one more bit for its left shift.
   localparam int DEN_BITS = VALUE_BITS + 1;
   localparam int REM_BITS = DEN_BITS + 1;

   typedef logic [COLOUR_BITS-1:0] colour_type;

   typedef struct packed {
      colour_type lo;
      colour_type hi;
   } span_type;

endpackage

// File: design/pcg_point_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_point_regs: breakpoint register file
// Holds one breakpoint value and colour per point, written from the csr port.
// ----------------------------------------------------------------------------
module pcg_point_regs import pcg_pkg::*; #(
   parameter int NUM_POINTS = NUM_POINTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [CSR_INDEX_BITS-1:0]            wr_index,
   input  logic [POINT_BITS-1:0]                wr_data,
   output logic [NUM_POINTS-1:0][POINT_BITS-1:0] points_o
);

   logic [NUM_POINTS-1:0][POINT_BITS-1:0] point_ff;
   logic [NUM_POINTS-1:0][POINT_BITS-1:0] point_in;

   // Writes to an index without a register are dropped.
   always_comb begin
      point_in = point_ff;
      for (int k = 0; k < NUM_POINTS; k++) begin
         if (wr_en && (k < REG_COUNT) && (wr_index == CSR_INDEX_BITS'(k))) begin
            point_in[k] = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff <= '0;
      end else begin
         point_ff <= point_in;
      end
   end

   assign points_o = point_ff;

endmodule

// File: design/pcg_segment_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_segment_select: segment search and divider setup
// Stage one compares the sample with every breakpoint; stage two picks the
// segment and forms the numerator, denominator and endpoint colours.
// ----------------------------------------------------------------------------
module pcg_segment_select import pcg_pkg::*; #(
   parameter int NUM_POINTS  = NUM_POINTS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 valid_i,
   input  logic [SAMPLE_BITS-1:0]               sample_i,
   input  logic [NUM_POINTS-1:0][POINT_BITS-1:0] points_i,
   output logic                                 valid_o,
   output logic [DEN_BITS-1:0]                  num_o,
   output logic [DEN_BITS-1:0]                  den_o,
   output span_type                             span_o
);

   localparam int CMP_BITS = (SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
   localparam int CMP_EXT  = CMP_BITS + 1;
   localparam int LAST     = NUM_POINTS - 1;
   localparam int IDX_BITS = $clog2(NUM_POINTS);

   // Stage one
   logic signed [CMP_BITS-1:0]  sample_ext;
   logic signed [CMP_BITS-1:0]  value_ext [NUM_POINTS];
   logic                        s1_valid_ff, s1_valid_in;
   logic signed [CMP_BITS-1:0]  s1_sample_ff;
   logic [NUM_POINTS-1:0]       s1_lt_ff, s1_lt_in;
   logic                        s1_below_ff, s1_below_in;
   logic                        s1_above_ff, s1_above_in;

   // Stage two
   logic [IDX_BITS-1:0]         sel_idx, prev_idx;
   logic [VALUE_BITS-1:0]       v_lo, v_hi;
   logic [CMP_BITS:0]           num_wide;
   logic                        s2_valid_ff, s2_valid_in;
   logic [DEN_BITS-1:0]         s2_num_ff, s2_num_in;
   logic [DEN_BITS-1:0]         s2_den_ff, s2_den_in;
   span_type                    s2_span_ff, s2_span_in;

   assign sample_ext = CMP_BITS'($signed(sample_i));

   always_comb begin
      for (int k = 0; k < NUM_POINTS; k++) begin
         value_ext[k] = CMP_BITS'($signed(points_i[k][POINT_BITS-1:VALUE_LSB]));
         s1_lt_in[k]  = value_ext[k] < sample_ext;
      end
      s1_below_in = sample_ext <= value_ext[0];
      s1_above_in = sample_ext > value_ext[LAST];
      s1_valid_in = valid_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sample_ff <= sample_ext;
         s1_lt_ff     <= s1_lt_in;
         s1_below_ff  <= s1_below_in;
         s1_above_ff  <= s1_above_in;
      end
   end

   // First inner breakpoint not below the sample, else the last one.
   always_comb begin
      sel_idx = IDX_BITS'(LAST);
      for (int k = LAST - 1; k >= 1; k--) begin
         if (!s1_lt_ff[k]) begin
            sel_idx = IDX_BITS'(k);
         end
      end
      prev_idx = sel_idx - IDX_BITS'(1);
      v_lo     = points_i[prev_idx][POINT_BITS-1:VALUE_LSB];
      v_hi     = points_i[sel_idx][POINT_BITS-1:VALUE_LSB];
      num_wide = {s1_sample_ff[CMP_BITS-1], s1_sample_ff} - CMP_EXT'($signed(v_lo));

      s2_valid_in = s1_valid_ff;
      s2_num_in   = num_wide[DEN_BITS-1:0];
      s2_den_in   = DEN_BITS'($signed(v_hi)) - DEN_BITS'($signed(v_lo));
      s2_span_in.lo = points_i[prev_idx][COLOUR_BITS-1:0];
      s2_span_in.hi = points_i[sel_idx][COLOUR_BITS-1:0];

      // Out-of-range samples take a flat span so the blend returns its colour.
      if (s1_below_ff || s1_above_ff) begin
         s2_num_in = '0;
         s2_den_in = DEN_BITS'(1);
         if (s1_below_ff) begin
            s2_span_in.lo = points_i[0][COLOUR_BITS-1:0];
         end else begin
            s2_span_in.lo = points_i[LAST][COLOUR_BITS-1:0];
         end
         s2_span_in.hi = s2_span_in.lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_span_ff <= s2_span_in;
      end
   end

   assign valid_o = s2_valid_ff;
   assign num_o   = s2_num_ff;
   assign den_o   = s2_den_ff;
   assign span_o  = s2_span_ff;

endmodule

// File: design/pcg_frac_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_frac_divider: pipelined restoring divider for the segment fraction
// One quotient bit per stage; the endpoint colours ride along with each item.
// ----------------------------------------------------------------------------
module pcg_frac_divider import pcg_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     valid_i,
   input  logic [DEN_BITS-1:0]      num_i,
   input  logic [DEN_BITS-1:0]      den_i,
   input  span_type                 span_i,
   output logic                     valid_o,
   output logic [FRACTION_BITS:0]   quo_o,
   output span_type                 span_o
);

   localparam int Q_BITS = FRACTION_BITS + 1;
   localparam int STAGES = Q_BITS;

   logic [STAGES-1:0]   valid_ff;
   logic [REM_BITS-1:0] rem_ff  [STAGES];
   logic [REM_BITS-1:0] rem_in  [STAGES];
   logic [DEN_BITS-1:0] den_ff  [STAGES];
   logic [DEN_BITS-1:0] den_in  [STAGES];
   logic [Q_BITS-1:0]   quo_ff  [STAGES];
   logic [Q_BITS-1:0]   quo_in  [STAGES];
   span_type            span_ff [STAGES];
   span_type            span_in [STAGES];
   logic [STAGES-1:0]   valid_in;

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      logic [REM_BITS-1:0] trial;
      logic [Q_BITS-1:0]   quo_src;
      logic                fits;

      // The first stage decides the integer bit, which is 0 or 1 since the
      // numerator never exceeds the denominator.
      if (j == 0) begin : g_first
         assign trial       = {1'b0, num_i};
         assign quo_src     = '0;
         assign den_in[j]   = den_i;
         assign span_in[j]  = span_i;
         assign valid_in[j] = valid_i;
      end else begin : g_next
         assign trial       = {rem_ff[j-1][REM_BITS-2:0], 1'b0};
         assign quo_src     = quo_ff[j-1];
         assign den_in[j]   = den_ff[j-1];
         assign span_in[j]  = span_ff[j-1];
         assign valid_in[j] = valid_ff[j-1];
      end

      assign fits      = trial >= {1'b0, den_in[j]};
      assign rem_in[j] = fits ? (trial - {1'b0, den_in[j]}) : trial;
      assign quo_in[j] = {quo_src[Q_BITS-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= valid_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= rem_in[j];
            den_ff[j]  <= den_in[j];
            quo_ff[j]  <= quo_in[j];
            span_ff[j] <= span_in[j];
         end
      end
   end

   assign valid_o = valid_ff[STAGES-1];
   assign quo_o   = quo_ff[STAGES-1];
   assign span_o  = span_ff[STAGES-1];

   // A stalled pipeline must neither drop nor create items.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("divider valid bits changed during a stall");

endmodule

// File: design/pcg_channel_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_channel_blend: per-channel linear interpolation
// Registers fraction times colour step for each channel, then adds the base.
// ----------------------------------------------------------------------------
module pcg_channel_blend import pcg_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_i,
   input  logic [FRACTION_BITS:0]  quo_i,
   input  span_type                span_i,
   output logic                    valid_o,
   output colour_type              rgb_o
);

   localparam int Q_BITS    = FRACTION_BITS + 1;
   localparam int DIFF_BITS = CHANNEL_BITS + 1;
   localparam int PROD_BITS = Q_BITS + 1 + DIFF_BITS + 1;

   logic                        valid_ff;
   logic signed [PROD_BITS-1:0] prod_ff [NUM_CHANNELS];
   logic signed [PROD_BITS-1:0] prod_in [NUM_CHANNELS];
   colour_type                  base_ff;
   logic signed [DIFF_BITS-1:0] diff    [NUM_CHANNELS];
   logic signed [PROD_BITS-1:0] total   [NUM_CHANNELS];

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         diff[c] = $signed({1'b0, span_i.hi[c*CHANNEL_BITS +: CHANNEL_BITS]})
                 - $signed({1'b0, span_i.lo[c*CHANNEL_BITS +: CHANNEL_BITS]});
         prod_in[c] = $signed({1'b0, quo_i}) * diff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         base_ff <= span_i.lo;
      end
   end

   // The sum always lies between the two endpoints, so the integer part is
   // the channel value with no clamping.
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         total[c] = prod_ff[c]
                  + $signed(PROD_BITS'({base_ff[c*CHANNEL_BITS +: CHANNEL_BITS],
                                        {FRACTION_BITS{1'b0}}}));
         rgb_o[c*CHANNEL_BITS +: CHANNEL_BITS] =
            total[c][FRACTION_BITS + CHANNEL_BITS - 1:FRACTION_BITS];
      end
   end

   assign valid_o = valid_ff;

endmodule

// File: design/piecewise_colour_gradient_map.sv
// Throughput: one item per cycle while the skid register is empty;
// the fraction divider retires one quotient bit per stage.
// Backpressure: a skid register behind the output keeps req_ready high while one
// result waits; the whole pipeline holds only once that skid register is full.
// Reset: synchronous, active high; clears all valid bits and the breakpoint registers.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_colour_gradient_map: piecewise-linear colour gradient, RGB888/RGB565
// Maps a signed sample onto a colour by linear interpolation between the two
// breakpoints that enclose it.
// ----------------------------------------------------------------------------
module piecewise_colour_gradient_map import pcg_pkg::*; #(
   parameter int NUM_POINTS    = NUM_POINTS_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Sample channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   // Colour channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COLOUR_BITS-1:0]    rsp_rgb_full,
   output logic [PACKED_BITS-1:0]    rsp_rgb_packed,
   // Breakpoint register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [POINT_BITS-1:0]     csr_data
);

   logic [NUM_POINTS-1:0][POINT_BITS-1:0] points;

   logic                      advance;
   logic                      sel_valid;
   logic [DEN_BITS-1:0]       sel_num;
   logic [DEN_BITS-1:0]       sel_den;
   span_type                  sel_span;
   logic                      div_valid;
   logic [FRACTION_BITS:0]    div_quo;
   span_type                  div_span;
   logic                      blend_valid;
   colour_type                blend_rgb;

   logic                      out_valid_ff, out_valid_in;
   colour_type                out_rgb_ff, out_rgb_in;
   logic                      skid_valid_ff, skid_valid_in;
   colour_type                skid_rgb_ff, skid_rgb_in;
   logic                      out_free;

   // Register writes are always taken; the register file ignores indexes
   // that have no breakpoint behind them.
   assign csr_ready = 1'b1;

   pcg_point_regs #(
      .NUM_POINTS (NUM_POINTS)
   ) u_point_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .points_o (points)
   );

   // Every pipeline stage moves together. The enable comes straight from a
   // register, so no ready path runs through the stages.
   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   // Stages 1-2: compare against all breakpoints, then choose the segment.
   pcg_segment_select #(
      .NUM_POINTS  (NUM_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_segment_select (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_i  (req_valid),
      .sample_i (req_sample),
      .points_i (points),
      .valid_o  (sel_valid),
      .num_o    (sel_num),
      .den_o    (sel_den),
      .span_o   (sel_span)
   );

   // FRACTION_BITS + 1 stages: fraction of the way along the segment.
   pcg_frac_divider #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_frac_divider (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (sel_valid),
      .num_i   (sel_num),
      .den_i   (sel_den),
      .span_i  (sel_span),
      .valid_o (div_valid),
      .quo_o   (div_quo),
      .span_o  (div_span)
   );

   // One stage of multipliers, then the base add feeding the output register.
   pcg_channel_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_channel_blend (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (div_valid),
      .quo_i   (div_quo),
      .span_i  (div_span),
      .valid_o (blend_valid),
      .rgb_o   (blend_rgb)
   );

   // Output register with a skid register behind it. When the output is
   // stalled the item leaving the pipeline parks in the skid register, and
   // the pipeline holds from the next cycle on. While the skid register is
   // full the pipeline is frozen, so its last stage is not consumed.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_rgb_in    = out_rgb_ff;
      skid_valid_in = skid_valid_ff;
      skid_rgb_in   = skid_rgb_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_rgb_in    = skid_rgb_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = blend_valid;
            out_rgb_in   = blend_rgb;
         end
      end else if (blend_valid && advance) begin
         skid_valid_in = 1'b1;
         skid_rgb_in   = blend_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rgb_ff  <= out_rgb_in;
      skid_rgb_ff <= skid_rgb_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_rgb_full = out_rgb_ff;

   // RGB565 keeps the top five, six and five bits of red, green and blue.
   assign rsp_rgb_packed = {out_rgb_ff[23:19], out_rgb_ff[15:10], out_rgb_ff[7:3]};

   // The skid register only fills behind a waiting output item.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while the output is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid register filled while the output was free");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid item not moved to the output when the output drained");

endmodule
